FILE: rtl/core/thmdc_pkg.sv
// Shared constants, types and reset values for the thermostat motor duty controller.
package thmdc_pkg;

   localparam int TEMP_W     = 16;
   localparam int COUNT_W    = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_FILL_W = RSP_DATA_W - (1 + MODE_W + 1 + COUNT_W + TEMP_W);
   localparam int BUF_DEPTH  = 2;

   // Motor modes.
   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd2;

   // Event kinds.
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORK_LIMIT       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LIMIT       = 2'd3;

   // Reset values.
   localparam logic signed [TEMP_W-1:0] TOP_THRESHOLD_RST    = 16'sd400;
   localparam logic signed [TEMP_W-1:0] BOTTOM_THRESHOLD_RST = 16'sd320;
   localparam logic [COUNT_W-1:0]       WORK_LIMIT_RST       = 16'd600;
   localparam logic [COUNT_W-1:0]       REST_LIMIT_RST       = 16'd300;
   localparam logic [TEMP_W-1:0]        LAST_READING_RST     = 16'hFFFF;

   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

endpackage

FILE: rtl/core/thermostat_motor_duty_controller.sv
// Each accepted request writes its result into the result buffer, which offers it on rsp_.
// Throughput: one transaction per cycle unless the buffer is full; updates are combinational.
// A two-entry result buffer keeps req_tready high while one result waits on the rsp_ side.
// Reset (synchronous, active high) sets the mode to off, the phase counter to zero,
// the last reading to -1, the registers to their defaults and empties the result buffer.
module thermostat_motor_duty_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [thmdc_pkg::REQ_DATA_W-1:0]     req_tdata,  // [15:0] temperature
   input  logic [thmdc_pkg::REQ_USER_W-1:0]     req_tuser,  // [0] cmd, [1] sensor_error
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] motor_drive, [2:1] motor_mode, [3] fault_led, [19:4] phase_ticks,
   // [35:20] last_temperature, [39:36] zero
   output logic [thmdc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration port.
   input  logic                                 csr_we,
   input  logic [thmdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [thmdc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic signed [thmdc_pkg::TEMP_W-1:0]  top_thr_ff;
   logic signed [thmdc_pkg::TEMP_W-1:0]  bottom_thr_ff;
   logic [thmdc_pkg::COUNT_W-1:0]        work_limit_ff;
   logic [thmdc_pkg::COUNT_W-1:0]        rest_limit_ff;

   logic [thmdc_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic [thmdc_pkg::COUNT_W-1:0]        phase_ff, phase_in;
   logic [thmdc_pkg::TEMP_W-1:0]         last_ff, last_in;

   thmdc_pkg::rsp_data_type              buf_ff [thmdc_pkg::BUF_DEPTH];
   logic                                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                           count_ff, count_in;

   logic                                 req_fire, rsp_fire;
   logic                                 is_sample, sensor_fault;
   logic signed [thmdc_pkg::TEMP_W-1:0]  temp;
   logic [thmdc_pkg::COUNT_W-1:0]        phase_inc;
   thmdc_pkg::rsp_data_type              rsp_word;

   assign is_sample    = (req_tuser[0] == thmdc_pkg::CMD_SAMPLE);
   assign sensor_fault = req_tuser[1];
   assign temp         = req_tdata[thmdc_pkg::TEMP_W-1:0];
   assign phase_inc    = phase_ff + 1'b1;

   assign req_tready = (count_ff != 2'(thmdc_pkg::BUF_DEPTH));
   assign rsp_tvalid = (count_ff != 2'd0);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = buf_ff[rd_ptr_ff];

   // Event handling: sensor errors win, then ticks count, then samples compare.
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      if (sensor_fault) begin
         if (mode_ff != thmdc_pkg::MODE_OFF) begin
            mode_in  = thmdc_pkg::MODE_OFF;
            phase_in = '0;
         end
      end else if (!is_sample) begin
         if (mode_ff == thmdc_pkg::MODE_ON) begin
            if (phase_inc >= work_limit_ff) begin
               mode_in  = thmdc_pkg::MODE_SLEEP;
               phase_in = '0;
            end else begin
               phase_in = phase_inc;
            end
         end else if (mode_ff == thmdc_pkg::MODE_SLEEP) begin
            if (phase_inc >= rest_limit_ff) begin
               mode_in  = thmdc_pkg::MODE_ON;
               phase_in = '0;
            end else begin
               phase_in = phase_inc;
            end
         end
      end else begin
         last_in = req_tdata[thmdc_pkg::TEMP_W-1:0];
         if (temp > top_thr_ff) begin
            if (mode_ff == thmdc_pkg::MODE_OFF) begin
               mode_in  = thmdc_pkg::MODE_ON;
               phase_in = '0;
            end
         end else if (temp < bottom_thr_ff) begin
            if (mode_ff != thmdc_pkg::MODE_OFF) begin
               mode_in  = thmdc_pkg::MODE_OFF;
               phase_in = '0;
            end
         end
      end
   end

   assign rsp_word = {{thmdc_pkg::RSP_FILL_W{1'b0}}, last_in, phase_in, sensor_fault, mode_in,
                      (mode_in == thmdc_pkg::MODE_ON)};

   always_comb begin
      count_in = count_ff;
      if (req_fire && !rsp_fire) begin
         count_in = count_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_thr_ff    <= thmdc_pkg::TOP_THRESHOLD_RST;
         bottom_thr_ff <= thmdc_pkg::BOTTOM_THRESHOLD_RST;
         work_limit_ff <= thmdc_pkg::WORK_LIMIT_RST;
         rest_limit_ff <= thmdc_pkg::REST_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            thmdc_pkg::CSR_TOP_THRESHOLD:    top_thr_ff    <= csr_wdata;
            thmdc_pkg::CSR_BOTTOM_THRESHOLD: bottom_thr_ff <= csr_wdata;
            thmdc_pkg::CSR_WORK_LIMIT:       work_limit_ff <= csr_wdata;
            thmdc_pkg::CSR_REST_LIMIT:       rest_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= thmdc_pkg::MODE_OFF;
         phase_ff  <= '0;
         last_ff   <= thmdc_pkg::LAST_READING_RST;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            mode_ff   <= mode_in;
            phase_ff  <= phase_in;
            last_ff   <= last_in;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_ff[wr_ptr_ff] <= rsp_word;
      end
   end

endmodule

FILE: rtl/core/thmdc_checker.sv
// Port-level checks for the thermostat motor duty controller, bound to the top level.
module thmdc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [thmdc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [thmdc_pkg::MODE_W-1:0]  rsp_mode;
   logic [thmdc_pkg::COUNT_W-1:0] rsp_phase;

   assign rsp_mode  = rsp_tdata[2:1];
   assign rsp_phase = rsp_tdata[19:4];

   // The drive pin follows the on mode in every result.
   a_drive_matches_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_mode == thmdc_pkg::MODE_ON)))
      else $error("motor_drive disagrees with motor_mode");

   // A reported sensor error always leaves the motor off.
   a_fault_forces_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (rsp_mode == thmdc_pkg::MODE_OFF))
      else $error("sensor error without motor off");

   // Nothing is counted while the motor is off.
   a_off_phase_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_mode == thmdc_pkg::MODE_OFF)) |-> (rsp_phase == '0))
      else $error("phase count nonzero while off");

   // No result is offered in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result transaction holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

endmodule

bind thermostat_motor_duty_controller thmdc_checker u_thmdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
